>>> rtl/tpq_pkg.sv
// Shared constants for the two-term power-of-two quantizer.
// Used by the term stage, the top level and the port checker; no dependencies.
package tpq_pkg;

    // Largest magnitude allowed for a term's index code.
    localparam int CODE_LIMIT = 7;

    // Width of the quantized result and of the padded output stream word.
    localparam int OUT_WIDTH  = 26;
    localparam int OUT_TW     = ((OUT_WIDTH + 7) / 8) * 8;

endpackage

>>> rtl/tpq_term.sv
// One quantization term: two register stages, leading-one search then round and subtract.
// Depends on tpq_pkg for the code limit and the result width.
module tpq_term
    import tpq_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int TERM_IDX   = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DATA_WIDTH:0]   i_resid,
    input  logic [OUT_WIDTH-1:0]  i_acc,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH:0]   o_resid,
    output logic [OUT_WIDTH-1:0]  o_acc
);

    localparam int RW     = DATA_WIDTH + 1;
    localparam int PW     = $clog2(RW);
    localparam int SW     = PW + 1;
    localparam int SH_LO  = FRAC_BITS + 1 - TERM_IDX - CODE_LIMIT;
    localparam int SH_HI  = FRAC_BITS + 1 - TERM_IDX + CODE_LIMIT;

    // Stage A: magnitude and leading-one position.
    logic                 r_a_valid;
    logic [RW-1:0]        r_a_resid;
    logic [RW-1:0]        r_a_mag;
    logic                 r_a_neg;
    logic [PW-1:0]        r_a_pos;
    logic [OUT_WIDTH-1:0] r_a_acc;

    // Stage B: updated residual and running sum.
    logic                 r_b_valid;
    logic [RW-1:0]        r_b_resid;
    logic [OUT_WIDTH-1:0] r_b_acc;

    logic                 w_ready_a;
    logic                 w_ready_b;

    logic                 n_neg;
    logic [RW-1:0]        n_mag;
    logic [PW-1:0]        n_pos;

    logic [RW:0]          w_mag2;
    logic [RW:0]          w_thr;
    logic                 w_up;
    logic [SW-1:0]        w_shift;
    logic                 w_in_range;
    logic                 w_take;
    logic [RW:0]          w_tmag;
    logic [RW:0]          w_rext;
    logic [RW-1:0]        n_resid;
    logic [OUT_WIDTH-1:0] n_acc;

    assign w_ready_b = !r_b_valid || i_ready;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    // Absolute value and priority encoder; the highest set bit wins.
    always_comb begin
        n_neg = i_resid[RW-1];
        n_mag = n_neg ? (~i_resid + RW'(1)) : i_resid;
        n_pos = '0;
        for (int k = 0; k < RW; k++) begin
            if (n_mag[k]) begin
                n_pos = PW'(k);
            end
        end
    end

    // Round up when 2*mag > 3*2^pos, then check the index code range.
    always_comb begin
        w_mag2     = {r_a_mag, 1'b0};
        w_thr      = (RW + 1)'(3) << r_a_pos;
        w_up       = w_mag2 > w_thr;
        w_shift    = SW'(r_a_pos) + SW'(w_up);
        w_in_range = (int'(w_shift) >= SH_LO) && (int'(w_shift) <= SH_HI);
        w_take     = (r_a_mag != '0) && w_in_range;
        w_tmag     = (RW + 1)'(1) << w_shift;
        w_rext     = {r_a_resid[RW-1], r_a_resid};
        n_resid    = r_a_resid;
        n_acc      = r_a_acc;
        if (w_take) begin
            if (r_a_neg) begin
                n_resid = RW'(w_rext + w_tmag);
                n_acc   = r_a_acc - OUT_WIDTH'(w_tmag);
            end else begin
                n_resid = RW'(w_rext - w_tmag);
                n_acc   = r_a_acc + OUT_WIDTH'(w_tmag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_a_valid <= i_valid;
            end
            if (w_ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_a_resid <= i_resid;
            r_a_mag   <= n_mag;
            r_a_neg   <= n_neg;
            r_a_pos   <= n_pos;
            r_a_acc   <= i_acc;
        end
        if (w_ready_b && r_a_valid) begin
            r_b_resid <= n_resid;
            r_b_acc   <= n_acc;
        end
    end

    assign o_valid = r_b_valid;
    assign o_resid = r_b_resid;
    assign o_acc   = r_b_acc;

endmodule

>>> rtl/two_term_power_of_two_quantizer.sv
// Each term is a leading-one stage and a round stage; a transaction passes through them in turn.
// Throughput: one transaction per cycle when the output is not stalled.
// Every stage carries its own valid bit and loads whenever the stage after it can move.
// Reset: synchronous, active low; clears all valid bits, payload registers are not reset.
// Top level; instantiates TERMS copies of tpq_term and takes constants from tpq_pkg.
module two_term_power_of_two_quantizer
    import tpq_pkg::*;
#(
    parameter int TERMS      = 2,
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0: weight (DATA_WIDTH bits, signed Q format), zero padding.
    input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0: quantized (26 bits, signed), zero padding.
    output logic [OUT_TW-1:0]                      m_axis_tdata
);

    localparam int RW = DATA_WIDTH + 1;

    // Stage boundaries between terms. Index 0 is the input side, index TERMS the
    // output side; the last term's second stage doubles as the output register.
    logic                 w_valid [TERMS+1];
    logic                 w_ready [TERMS+1];
    logic [RW-1:0]        w_resid [TERMS+1];
    logic [OUT_WIDTH-1:0] w_acc   [TERMS+1];

    // The residual starts as the sign-extended weight and the sum starts at zero.
    assign w_valid[0]    = s_axis_tvalid;
    assign s_axis_tready = w_ready[0];
    assign w_resid[0]    = {s_axis_tdata[DATA_WIDTH-1], s_axis_tdata[DATA_WIDTH-1:0]};
    assign w_acc[0]      = '0;

    for (genvar g = 0; g < TERMS; g++) begin : g_term
        tpq_term #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .TERM_IDX   (g)
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_resid (w_resid[g]),
            .i_acc   (w_acc[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_resid (w_resid[g+1]),
            .o_acc   (w_acc[g+1])
        );
    end

    // Output side: the sum is already truncated to the result width.
    assign w_ready[TERMS] = m_axis_tready;
    assign m_axis_tvalid  = w_valid[TERMS];
    assign m_axis_tdata   = {{(OUT_TW - OUT_WIDTH){1'b0}}, w_acc[TERMS]};

endmodule

>>> rtl/tpq_checker.sv
// Port-level checker for the quantizer, attached by the bind at the end of this file.
// Depends on tpq_pkg for the output word layout.
module tpq_checker
    import tpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tready,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [OUT_TW-1:0] m_axis_tdata
);

    // A held result keeps its value until the transaction completes.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The padding above the result is always zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TW-1:OUT_WIDTH] == '0)
        else $error("nonzero padding in result word");

    // With no result waiting, or with the sink ready, the input side is never blocked.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled without back pressure");

    // Reset empties the pipeline.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind two_term_power_of_two_quantizer tpq_checker u_tpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for two_term_power_of_two_quantizer.
// Drives random and corner-case weights, predicts each quantized sum in the
// bench and checks every output transaction; depends on the RTL and tpq_pkg.
`timescale 1ns / 1ps

module testbench;
    import tpq_pkg::*;

    // Configuration of the block under test; the predictor uses the same values.
    localparam int N_TERMS     = 2;
    localparam int FRAC        = 16;
    localparam int WEIGHT_W    = 32;
    localparam int IN_TW       = ((WEIGHT_W + 7) / 8) * 8;

    // Run length and pressure points.
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_AT      = 500;     // result count that starts the long receiver hold
    localparam int LONG_HOLD    = 300;     // cycles the receiver refuses results
    localparam int DRAIN_AT     = 1000;    // random item that waits for an empty pipeline
    localparam int CYCLE_LIMIT  = 600000;

    // One pending input transaction. When drain_first is set, the sender holds
    // the item back until every earlier result has been received.
    typedef struct {
        logic [WEIGHT_W-1:0] weight;
        bit                  drain_first;
    } t_weight_item;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // Fields from bit 0: weight (32 bits, signed Q16.16), no padding at this width.
    logic [IN_TW-1:0]     s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // Fields from bit 0: quantized (26 bits, signed Q10.16), zero padding.
    logic [OUT_TW-1:0]    m_axis_tdata;

    t_weight_item         weight_queue[$];
    logic [OUT_WIDTH-1:0] expected_quant[$];

    int error_count  = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int tx_gap       = 0;
    int tx_calm      = 0;
    int rx_stall     = 0;
    int rx_calm      = 0;

    two_term_power_of_two_quantizer #(
        .TERMS      (N_TERMS),
        .FRAC_BITS  (FRAC),
        .DATA_WIDTH (WEIGHT_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Greedy approximation of a weight by signed powers of two. Each term takes
    // the leading one of the residual's magnitude, rounds the exponent up only
    // when the magnitude is strictly above 1.5 times that power, and is dropped
    // when its index code falls outside the allowed range.
    function automatic logic [OUT_WIDTH-1:0] quantize_weight(
        input logic signed [WEIGHT_W-1:0] weight
    );
        longint          residual;
        longint          sum;
        longint          term;
        longint unsigned mag;
        int              msb;
        int              shift;
        int              code;
        residual = weight;
        sum      = 0;
        for (int n = 0; n < N_TERMS; n++) begin
            if (residual != 0) begin
                mag = (residual < 0) ? -residual : residual;
                msb = 0;
                for (int b = 0; b < 64; b++) begin
                    if (mag[b]) msb = b;
                end
                // A leading one at bit zero can never be rounded up.
                shift = msb;
                if (msb >= 1 && mag > (64'd3 << (msb - 1))) shift = msb + 1;
                code = 1 - n - (shift - FRAC);
                if (code <= CODE_LIMIT && code >= -CODE_LIMIT) begin
                    term = longint'(1) << shift;
                    if (residual < 0) term = -term;
                    sum      += term;
                    residual -= term;
                end
            end
        end
        return sum[OUT_WIDTH-1:0];
    endfunction

    // Idle length for either side: mostly none, some short, a few long, and
    // now and then a calm stretch with no idling at all.
    function automatic int next_gap(inout int calm_left);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (roll < 4) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random weight. Most weights have their leading one where the terms can
    // land, some sit right at a rounding threshold, and the rest are raw words.
    function automatic longint random_weight();
        int     roll;
        int     k;
        longint mag;
        roll = $urandom_range(0, 99);
        if (roll < 30) return longint'($urandom);
        if (roll < 80) begin
            k   = $urandom_range(0, 28);
            mag = (longint'(1) << k) | (longint'($urandom) & ((longint'(1) << k) - 1));
        end else begin
            k   = $urandom_range(1, 30);
            mag = (longint'(3) << (k - 1)) + $urandom_range(0, 2) - 1;
        end
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic add_weight(input longint value, input bit drain);
        t_weight_item item;
        item.weight      = value[WEIGHT_W-1:0];
        item.drain_first = drain;
        weight_queue.push_back(item);
    endtask

    task automatic report_error(input string msg);
        if (error_count < 10) $display("ERROR: %s", msg);
        error_count++;
    endtask

    // Sender. A transaction completes when tvalid and tready are both high at
    // the edge; the expectation for it is computed right there. A new item is
    // offered only when the current one is gone, so tvalid never drops while
    // an item waits for tready.
    always @(posedge i_clk) begin : drive_weights
        t_weight_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_quant.push_back(quantize_weight(s_axis_tdata[WEIGHT_W-1:0]));
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (weight_queue.size() > 0 &&
                             (!weight_queue[0].drain_first || expected_quant.size() == 0)) begin
                    item = weight_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TW'(item.weight);
                    tx_gap = next_gap(tx_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every completed output transaction is compared with the oldest
    // expectation. After one particular result the receiver holds off for a
    // long stretch so that the pipeline fills and the block stalls its input.
    always @(posedge i_clk) begin : watch_results
        logic [OUT_WIDTH-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_quant.size() == 0) begin
                    report_error($sformatf("result %0d with nothing expected: got %0d",
                                           results_seen,
                                           $signed(m_axis_tdata[OUT_WIDTH-1:0])));
                end else begin
                    want = expected_quant.pop_front();
                    if (m_axis_tdata[OUT_WIDTH-1:0] !== want) begin
                        report_error($sformatf("result %0d quantized: expected %0d, got %0d",
                                               results_seen, $signed(want),
                                               $signed(m_axis_tdata[OUT_WIDTH-1:0])));
                    end
                end
                rx_stall = (results_seen == HOLD_AT) ? LONG_HOLD : next_gap(rx_calm);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that stops making progress ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        // Directed part: zero, unit steps, the extremes of the word, values on
        // both sides of the 1.5 rounding threshold, the edges of the code range,
        // a leading one at bit zero and one at bit one, and alternating patterns.
        add_weight(0, 1'b0);
        add_weight(1, 1'b0);
        add_weight(-1, 1'b0);
        add_weight(32'h7FFF_FFFF, 1'b0);
        add_weight(-longint'(32'h8000_0000), 1'b0);
        add_weight(32'h0001_0000, 1'b0);
        add_weight(-longint'(32'h0001_0000), 1'b0);
        add_weight(32'h0001_8000, 1'b0);
        add_weight(32'h0001_8001, 1'b0);
        add_weight(-longint'(32'h0001_8001), 1'b0);
        add_weight(32'h0000_0400, 1'b0);
        add_weight(32'h0000_03FF, 1'b0);
        add_weight(32'h0000_0601, 1'b0);
        add_weight(32'h00FF_FFFF, 1'b0);
        add_weight(32'h0100_0000, 1'b0);
        add_weight(32'h017F_FFFF, 1'b0);
        add_weight(32'h0180_0001, 1'b0);
        add_weight(-longint'(32'h0180_0000), 1'b0);
        add_weight(2, 1'b0);
        add_weight(3, 1'b0);
        add_weight(32'h0001_2345, 1'b0);
        add_weight(32'hAAAA_AAAA, 1'b0);
        add_weight(32'h5555_5555, 1'b0);
        add_weight(32'h00C0_0001, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            add_weight(random_weight(), i == DRAIN_AT);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item has been accepted and every result received,
        // then give the pipeline time to show any stray extra result.
        while (weight_queue.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_quant.size() > 0) @(posedge i_clk);
        repeat (2 * N_TERMS + 20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> two_term_power_of_two_quantizer.f
rtl/tpq_pkg.sv
rtl/tpq_term.sv
rtl/two_term_power_of_two_quantizer.sv
rtl/tpq_checker.sv
tb/sv/testbench.sv
